### rtl/utf8v_pkg.sv
// Package with the constants and the code point check of the UTF-8 text validator.
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 21;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TWO   = 2'd1;
    localparam logic [1:0] KIND_THREE = 2'd2;
    localparam logic [1:0] KIND_FOUR  = 2'd3;

    localparam logic [ByteW-1:0] CONT_MASK  = 8'hc0;
    localparam logic [ByteW-1:0] CONT_MARK  = 8'h80;
    localparam logic [ByteW-1:0] LEAD2_LO   = 8'hc2;
    localparam logic [ByteW-1:0] LEAD2_HI   = 8'hdf;
    localparam logic [ByteW-1:0] LEAD3_LO   = 8'he0;
    localparam logic [ByteW-1:0] LEAD3_HI   = 8'hef;
    localparam logic [ByteW-1:0] LEAD4_LO   = 8'hf0;
    localparam logic [ByteW-1:0] LEAD4_HI   = 8'hf4;
    localparam logic [ByteW-1:0] ASCII_TOP  = 8'h80;
    localparam logic [ByteW-1:0] CTRL_TOP   = 8'h20;
    localparam logic [ByteW-1:0] CHAR_DEL   = 8'h7f;
    localparam logic [ByteW-1:0] CHAR_LF    = 8'h0a;

    localparam logic [CodeW-1:0] MIN_THREE  = 21'h000800;
    localparam logic [CodeW-1:0] MIN_FOUR   = 21'h010000;
    localparam logic [CodeW-1:0] SURR_LO    = 21'h00d800;
    localparam logic [CodeW-1:0] SURR_HI    = 21'h00dfff;
    localparam logic [CodeW-1:0] CODE_MAX   = 21'h10ffff;
    localparam logic [CodeW-1:0] C1_LO      = 21'h000080;
    localparam logic [CodeW-1:0] C1_HI      = 21'h00009f;

    // A completed sequence is refused when it is overlong, a surrogate, out of range
    // or a C1 control.
    function automatic logic code_rejected(input logic [1:0] kind, input logic [CodeW-1:0] cp);
        logic bad;
        bad = 1'b0;
        if (kind == KIND_THREE && cp < MIN_THREE)
        begin
            bad = 1'b1;
        end
        if (kind == KIND_FOUR && cp < MIN_FOUR)
        begin
            bad = 1'b1;
        end
        if (cp >= SURR_LO && cp <= SURR_HI)
        begin
            bad = 1'b1;
        end
        if (cp > CODE_MAX)
        begin
            bad = 1'b1;
        end
        if (cp >= C1_LO && cp <= C1_HI)
        begin
            bad = 1'b1;
        end
        return bad;
    endfunction

endpackage

`default_nettype wire

### rtl/utf8_text_validator_top.sv
// Top level of the UTF-8 text validator: input register, byte check and result register.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid / in_stall        data_byte, last_byte
//   out       output     out_valid / out_stall      text_valid
//   cfg       input      cfg_write_en               cfg_write_data (line feed accepted)
//
// One byte is taken in every cycle while in_stall is low; the verdict is written to the
// result register when the last byte of a string leaves the input register.
// The rate is set by the single pass through the byte check between the input register
// and the string state registers.
// Reset clears the string state, the pipeline valids and the line feed setting.
// A last byte waits in the input register while the result register holds a verdict that
// is stalled, and in_stall is raised for that time.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_validator_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic       cfg_write_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            text_valid
);

    localparam int unsigned CodeW = utf8v_pkg::CodeW;

    logic                 lf_accept_reg;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [7:0]           s1_byte_reg;
    logic                 s1_last_reg;
    logic [1:0]           pending_reg;
    logic [1:0]           pending_next;
    logic [1:0]           kind_reg;
    logic [1:0]           kind_next;
    logic [CodeW-1:0]     accum_reg;
    logic [CodeW-1:0]     accum_next;
    logic                 error_reg;
    logic                 error_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 text_valid_reg;
    logic                 text_valid_next;

    logic                 in_accept;
    logic                 out_free;
    logic                 s1_go;
    logic [CodeW-1:0]     accum_shift;
    logic [1:0]           pending_dec;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_go     = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    assign accum_shift = {accum_reg[CodeW-7:0], s1_byte_reg[5:0]};
    assign pending_dec = pending_reg - 2'd1;

    always_comb
    begin
        pending_next = pending_reg;
        kind_next    = kind_reg;
        accum_next   = accum_reg;
        error_next   = error_reg;
        if (!error_reg)
        begin
            if (pending_reg != 2'd0)
            begin
                if ((s1_byte_reg & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_MARK)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    accum_next   = accum_shift;
                    pending_next = pending_dec;
                    if (pending_dec == 2'd0 && utf8v_pkg::code_rejected(kind_reg, accum_shift))
                    begin
                        error_next = 1'b1;
                    end
                end
            end
            else if (s1_byte_reg < utf8v_pkg::ASCII_TOP)
            begin
                if (s1_byte_reg == utf8v_pkg::CHAR_LF && lf_accept_reg)
                begin
                    error_next = 1'b0;
                end
                else if (s1_byte_reg < utf8v_pkg::CTRL_TOP || s1_byte_reg == utf8v_pkg::CHAR_DEL)
                begin
                    error_next = 1'b1;
                end
            end
            else if (s1_byte_reg >= utf8v_pkg::LEAD2_LO && s1_byte_reg <= utf8v_pkg::LEAD2_HI)
            begin
                accum_next   = {{(CodeW-5){1'b0}}, s1_byte_reg[4:0]};
                kind_next    = utf8v_pkg::KIND_TWO;
                pending_next = 2'd1;
            end
            else if (s1_byte_reg >= utf8v_pkg::LEAD3_LO && s1_byte_reg <= utf8v_pkg::LEAD3_HI)
            begin
                accum_next   = {{(CodeW-4){1'b0}}, s1_byte_reg[3:0]};
                kind_next    = utf8v_pkg::KIND_THREE;
                pending_next = 2'd2;
            end
            else if (s1_byte_reg >= utf8v_pkg::LEAD4_LO && s1_byte_reg <= utf8v_pkg::LEAD4_HI)
            begin
                accum_next   = {{(CodeW-3){1'b0}}, s1_byte_reg[2:0]};
                kind_next    = utf8v_pkg::KIND_FOUR;
                pending_next = 2'd3;
            end
            else
            begin
                error_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        text_valid_next = text_valid_reg;
        if (s1_go && s1_last_reg)
        begin
            out_valid_next  = 1'b1;
            text_valid_next = !error_next && (pending_next == 2'd0);
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lf_accept_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            pending_reg   <= 2'd0;
            kind_reg      <= utf8v_pkg::KIND_NONE;
            accum_reg     <= '0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                lf_accept_reg <= cfg_write_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_go)
            begin
                if (s1_last_reg)
                begin
                    pending_reg <= 2'd0;
                    kind_reg    <= utf8v_pkg::KIND_NONE;
                    accum_reg   <= '0;
                    error_reg   <= 1'b0;
                end
                else
                begin
                    pending_reg <= pending_next;
                    kind_reg    <= kind_next;
                    accum_reg   <= accum_next;
                    error_reg   <= error_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        text_valid_reg <= text_valid_next;
    end

    assign out_valid  = out_valid_reg;
    assign text_valid = text_valid_reg;

endmodule

`default_nettype wire

### verif/utf8_verdict_sb_pkg.sv
// Scoreboard class that predicts and checks the verdicts of the UTF-8 text validator.
`timescale 1ns / 1ps

package utf8_verdict_sb_pkg;

    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } seq_kind_e;

    localparam logic [7:0] BYTE_LF      = 8'h0a;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_DEL     = 8'h7f;
    localparam logic [7:0] BYTE_HIGH    = 8'h80;
    localparam logic [7:0] TAIL_MASK    = 8'hc0;
    localparam logic [7:0] TAIL_TAG     = 8'h80;
    localparam logic [20:0] CP_C1_LO    = 21'h000080;
    localparam logic [20:0] CP_C1_HI    = 21'h00009f;
    localparam logic [20:0] CP_THREE_LO = 21'h000800;
    localparam logic [20:0] CP_SURR_LO  = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00dfff;
    localparam logic [20:0] CP_FOUR_LO  = 21'h010000;
    localparam logic [20:0] CP_TOP      = 21'h10ffff;

    class verdict_scoreboard;
        logic        newline_ok;
        logic [1:0]  tails_left;
        seq_kind_e   open_kind;
        logic [20:0] code_point;
        logic        string_bad;
        logic        verdict_q[$];
        int          errors;
        int          bytes_seen;
        int          strings_seen;
        int          strings_accepted;

        function new();
            newline_ok = 1'b0;
            errors = 0;
            bytes_seen = 0;
            strings_seen = 0;
            strings_accepted = 0;
            clear_string();
        endfunction

        function void clear_string();
            tails_left = 2'd0;
            open_kind = SEQ_NONE;
            code_point = '0;
            string_bad = 1'b0;
        endfunction

        function void set_newline(logic value);
            newline_ok = value;
        endfunction

        function logic code_illegal(seq_kind_e kind, logic [20:0] cp);
            return (kind == SEQ_THREE && cp < CP_THREE_LO)
                || (kind == SEQ_FOUR && cp < CP_FOUR_LO)
                || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                || (cp > CP_TOP)
                || (cp >= CP_C1_LO && cp <= CP_C1_HI);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic verdict;
            bytes_seen++;
            if (!string_bad)
            begin
                if (tails_left != 2'd0)
                begin
                    if ((b & TAIL_MASK) != TAIL_TAG)
                    begin
                        string_bad = 1'b1;
                    end
                    else
                    begin
                        code_point = {code_point[14:0], b[5:0]};
                        tails_left = tails_left - 2'd1;
                        if (tails_left == 2'd0 && code_illegal(open_kind, code_point))
                        begin
                            string_bad = 1'b1;
                        end
                    end
                end
                else if (b < BYTE_HIGH)
                begin
                    if (!(b == BYTE_LF && newline_ok) && (b < BYTE_SPACE || b == BYTE_DEL))
                    begin
                        string_bad = 1'b1;
                    end
                end
                else if (b >= 8'hc2 && b <= 8'hdf)
                begin
                    code_point = {16'd0, b[4:0]};
                    open_kind = SEQ_TWO;
                    tails_left = 2'd1;
                end
                else if (b >= 8'he0 && b <= 8'hef)
                begin
                    code_point = {17'd0, b[3:0]};
                    open_kind = SEQ_THREE;
                    tails_left = 2'd2;
                end
                else if (b >= 8'hf0 && b <= 8'hf4)
                begin
                    code_point = {18'd0, b[2:0]};
                    open_kind = SEQ_FOUR;
                    tails_left = 2'd3;
                end
                else
                begin
                    string_bad = 1'b1;
                end
            end
            if (last)
            begin
                verdict = !string_bad && tails_left == 2'd0;
                verdict_q.push_back(verdict);
                strings_seen++;
                if (verdict)
                begin
                    strings_accepted++;
                end
                clear_string();
            end
        endfunction

        function void check_verdict(logic got);
            logic want;
            if (verdict_q.size() == 0)
            begin
                $error("text_valid: unexpected result, actual %0b", got);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got !== want)
                begin
                    $error("text_valid mismatch: expected %0b, actual %0b", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

### verif/tb_utf8_text_validator_top.sv
// Self-checking testbench of the UTF-8 text validator driven with directed and random strings.
`timescale 1ns / 1ps

module tb_utf8_text_validator_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1200;
    localparam int SETTLE       = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic       cfg_write_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       text_valid;

    utf8_verdict_sb_pkg::verdict_scoreboard sb = new();
    logic [7:0] text_q[$];
    bit         calm = 1'b0;
    int         cycles = 0;
    int         random_bytes = 0;

    utf8_text_validator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .text_valid     (text_valid)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_utf8_text_validator_top: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_verdict(text_valid);
            end
            out_stall <= !calm && $urandom_range(99) < 6;
        end
    end

    function automatic logic [7:0] tail_byte(input int hi, input int lo);
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_byte(b, last);
    endtask

    task automatic send_string();
        for (int i = 0; i < text_q.size(); i++)
        begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_newline(input logic value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.set_newline(value);
    endtask

    task automatic add_broken();
        int pick;
        pick = $urandom_range(6);
        case (pick)
            0:
            begin
                text_q.push_back(8'he0);
                text_q.push_back(tail_byte(8'h9f, 8'h80));
                text_q.push_back(tail_byte(8'hbf, 8'h80));
            end
            1:
            begin
                text_q.push_back(8'hf0);
                text_q.push_back(tail_byte(8'h8f, 8'h80));
                text_q.push_back(tail_byte(8'hbf, 8'h80));
                text_q.push_back(tail_byte(8'hbf, 8'h80));
            end
            2:
            begin
                text_q.push_back(8'hed);
                text_q.push_back(tail_byte(8'hbf, 8'ha0));
                text_q.push_back(tail_byte(8'hbf, 8'h80));
            end
            3:
            begin
                text_q.push_back(tail_byte(8'hf4, 8'hf4));
                text_q.push_back(tail_byte(8'hbf, 8'h90));
                text_q.push_back(tail_byte(8'hbf, 8'h80));
                text_q.push_back(tail_byte(8'hbf, 8'h80));
            end
            4:
            begin
                text_q.push_back(8'hc2);
                text_q.push_back(tail_byte(8'h9f, 8'h80));
            end
            5:
            begin
                text_q.push_back($urandom_range(1) ? tail_byte(8'hc1, 8'h80)
                                                   : tail_byte(8'hff, 8'hf5));
            end
            default:
            begin
                text_q.push_back(tail_byte(8'hf4, 8'hc2));
                text_q.push_back(tail_byte(8'h7e, 8'h20));
            end
        endcase
    endtask

    task automatic add_char(input bit clean);
        int sel;
        logic [7:0] lead;
        sel = clean ? $urandom_range(74) : $urandom_range(99);
        if (sel < 40)
        begin
            text_q.push_back(tail_byte(8'h7e, 8'h20));
        end
        else if (sel < 52)
        begin
            lead = tail_byte(8'hdf, 8'hc2);
            text_q.push_back(lead);
            text_q.push_back(lead == 8'hc2 ? tail_byte(8'hbf, 8'ha0) : tail_byte(8'hbf, 8'h80));
        end
        else if (sel < 64)
        begin
            lead = tail_byte(8'hef, 8'he0);
            text_q.push_back(lead);
            if (lead == 8'he0)
            begin
                text_q.push_back(tail_byte(8'hbf, 8'ha0));
            end
            else if (lead == 8'hed)
            begin
                text_q.push_back(tail_byte(8'h9f, 8'h80));
            end
            else
            begin
                text_q.push_back(tail_byte(8'hbf, 8'h80));
            end
            text_q.push_back(tail_byte(8'hbf, 8'h80));
        end
        else if (sel < 72)
        begin
            lead = tail_byte(8'hf4, 8'hf0);
            text_q.push_back(lead);
            if (lead == 8'hf0)
            begin
                text_q.push_back(tail_byte(8'hbf, 8'h90));
            end
            else if (lead == 8'hf4)
            begin
                text_q.push_back(tail_byte(8'h8f, 8'h80));
            end
            else
            begin
                text_q.push_back(tail_byte(8'hbf, 8'h80));
            end
            text_q.push_back(tail_byte(8'hbf, 8'h80));
            text_q.push_back(tail_byte(8'hbf, 8'h80));
        end
        else if (sel < 75)
        begin
            text_q.push_back(utf8_verdict_sb_pkg::BYTE_LF);
        end
        else if (sel < 82)
        begin
            text_q.push_back(tail_byte(8'hff, 8'h00));
        end
        else if (sel < 86)
        begin
            text_q.push_back($urandom_range(3) == 0 ? utf8_verdict_sb_pkg::BYTE_DEL
                                                    : tail_byte(8'h1f, 8'h00));
        end
        else
        begin
            add_broken();
        end
    endtask

    task automatic build_string();
        bit clean;
        int n;
        clean = $urandom_range(99) < 75;
        n = $urandom_range(8, 1);
        text_q.delete();
        repeat (n) add_char(clean);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text_q = {8'h41};                     send_string();
        text_q = {8'h00};                     send_string();
        text_q = {8'h7f};                     send_string();
        text_q = {8'h0a};                     send_string();
        text_q = {8'hff};                     send_string();
        text_q = {8'hc2, 8'h80};              send_string();
        text_q = {8'he0, 8'h9f, 8'hbf};       send_string();
        text_q = {8'hed, 8'ha0, 8'h80};       send_string();
        text_q = {8'hf4, 8'h90, 8'h80, 8'h80}; send_string();
        text_q = {8'he2, 8'h82};              send_string();
        text_q = {8'hc3, 8'h28};              send_string();
        drain();
        write_newline(1'b1);
        text_q = {8'h0a};                     send_string();
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_newline(phase[0]);
            while (random_bytes < (phase + 1) * (RANDOM_BYTES / 4))
            begin
                calm = random_bytes >= 500 && random_bytes < 800;
                build_string();
                random_bytes += text_q.size();
                send_string();
            end
            drain();
        end

        $display("Sent %0d bytes in %0d strings under both newline modes; %0d verdicts were 1.",
                 sb.bytes_seen, sb.strings_seen, sb.strings_accepted);
        if (sb.errors == 0)
        begin
            $display("tb_utf8_text_validator_top: clean");
        end
        else
        begin
            $display("tb_utf8_text_validator_top: errors");
        end
        $finish;
    end

endmodule
